FILE: design/rcf_pkg.sv
// Package for the continued fraction expander: widths, sequencer codes and
// the request word passed from the sequencer to the shared divider.
// No dependencies.
package rcf_pkg;

    // Field widths
    localparam int VALUE_WIDTH = 32;
    localparam int DEN_WIDTH   = VALUE_WIDTH - 1;
    localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);
    localparam int LIMIT_WIDTH = 6;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 6'd63;
    localparam logic [STEP_WIDTH-1:0]  STEP_FIRST  = STEP_WIDTH'(VALUE_WIDTH - 1);

    // Sequencer state codes
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    // Request to the divider
    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [DEN_WIDTH-1:0]   divisor;
    } div_req_t;

    // Result from the divider
    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DEN_WIDTH-1:0]   remainder;
    } div_rsp_t;

endpackage

FILE: design/rational_to_continued_fraction_top.sv
// Top level of the continued fraction expander: term sequencer, sign fix-up
// and output register around the shared divider. Depends on rcf_pkg, rcf_div.
//
// Each fraction is expanded by the Euclidean algorithm with floor quotients,
// one term per division on a single serial divider that yields one quotient
// bit per clock. Each division runs one divide step per quotient bit, then
// the term is registered and offered until the consumer accepts it. The next
// division starts on the edge that accepts the word. A fraction gives at
// most 64 terms. A zero denominator gives a single error word, offered in
// the cycle after the fraction is taken. in_ready is high only while no
// fraction is in progress. term_limit may be written at any time the block
// is idle; cfg_ready is always high.
module rational_to_continued_fraction_top
    import rcf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    // Input fractions
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [VALUE_WIDTH-1:0] numerator,
    input  logic [DEN_WIDTH-1:0]          denominator,
    // Output terms
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [VALUE_WIDTH-1:0] term,
    output logic                          last_term,
    output logic                          truncated,
    output logic                          zero_denominator,
    // Term limit register
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [LIMIT_WIDTH-1:0]        cfg_data
);

    logic [1:0]             state_reg, state_next;
    logic [LIMIT_WIDTH-1:0] limit_reg;
    logic [LIMIT_WIDTH-1:0] count_reg, count_next;
    logic                   neg_reg, neg_next;
    logic                   last_reg, last_next;
    logic [DEN_WIDTH-1:0]   p_reg, p_next;
    logic [DEN_WIDTH-1:0]   q_reg, q_next;

    logic [VALUE_WIDTH-1:0] term_reg, term_next;
    logic                   trunc_reg, trunc_next;
    logic                   zden_reg, zden_next;

    div_req_t               req;
    div_rsp_t               rsp;

    logic                   in_word;
    logic                   out_word;
    logic [VALUE_WIDTH-1:0] num_abs;
    logic                   rem_zero;
    logic                   cut;
    logic [VALUE_WIDTH-1:0] fixed_term;
    logic [DEN_WIDTH-1:0]   fixed_rem;

    assign in_word  = in_valid && (state_reg == ST_IDLE);
    assign out_word = out_ready && (state_reg == ST_OUT);
    assign num_abs  = numerator[VALUE_WIDTH-1] ? (VALUE_WIDTH'(0) - numerator)
                                               : numerator;

    // Floor correction for a negative first numerator
    assign rem_zero = (rsp.remainder == '0);
    always_comb
    begin
        if (neg_reg)
        begin
            fixed_term = rem_zero ? (VALUE_WIDTH'(0) - rsp.quotient) : ~rsp.quotient;
            fixed_rem  = rem_zero ? '0 : (q_reg - rsp.remainder);
        end
        else
        begin
            fixed_term = rsp.quotient;
            fixed_rem  = rsp.remainder;
        end
    end
    assign cut = !rem_zero && (count_reg == limit_reg);

    // Divider requests: first term on accept, later terms once a word leaves
    always_comb
    begin
        req.start    = 1'b0;
        req.dividend = {1'b0, p_reg};
        req.divisor  = q_reg;
        if (in_word)
        begin
            req.start    = (denominator != '0);
            req.dividend = num_abs;
            req.divisor  = denominator;
        end
        else if (out_word && !last_reg)
        begin
            req.start = 1'b1;
        end
    end

    rcf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        neg_next   = neg_reg;
        last_next  = last_reg;
        p_next     = p_reg;
        q_next     = q_reg;
        term_next  = term_reg;
        trunc_next = trunc_reg;
        zden_next  = zden_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_word)
                begin
                    count_next = '0;
                    neg_next   = numerator[VALUE_WIDTH-1];
                    q_next     = denominator;
                    if (denominator == '0)
                    begin
                        term_next  = '0;
                        trunc_next = 1'b0;
                        zden_next  = 1'b1;
                        last_next  = 1'b1;
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                if (rsp.done)
                begin
                    term_next  = fixed_term;
                    trunc_next = cut;
                    zden_next  = 1'b0;
                    last_next  = rem_zero || cut;
                    neg_next   = 1'b0;
                    p_next     = q_reg;
                    q_next     = fixed_rem;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_word)
                begin
                    if (last_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            neg_reg   <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            neg_reg   <= neg_next;
            last_reg  <= last_next;
        end
    end

    // Term limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= cfg_data;
        end
    end

    // Operands and output word
    always_ff @(posedge clk)
    begin
        p_reg     <= p_next;
        q_reg     <= q_next;
        term_reg  <= term_next;
        trunc_reg <= trunc_next;
        zden_reg  <= zden_next;
    end

    assign in_ready         = (state_reg == ST_IDLE);
    assign out_valid        = (state_reg == ST_OUT);
    assign term             = term_reg;
    assign last_term        = last_reg;
    assign truncated        = trunc_reg;
    assign zero_denominator = zden_reg;
    assign cfg_ready        = 1'b1;

endmodule

FILE: design/rcf_div.sv
// Serial restoring divider: unsigned dividend over a positive divisor,
// one quotient bit per cycle. Depends on rcf_pkg.
module rcf_div
    import rcf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [STEP_WIDTH-1:0]  cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [DEN_WIDTH-1:0]   dsr_reg, dsr_next;

    logic [VALUE_WIDTH-1:0] trial;
    logic [VALUE_WIDTH-1:0] dsr_ext;
    logic                   fits;

    // One shift-compare-subtract step
    assign trial   = {rem_reg[VALUE_WIDTH-2:0], quo_reg[VALUE_WIDTH-1]};
    assign dsr_ext = {1'b0, dsr_reg};
    assign fits    = (trial >= dsr_ext);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_FIRST;
            rem_next  = '0;
            quo_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - dsr_ext) : trial;
            quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg[DEN_WIDTH-1:0];

endmodule

FILE: bench/rational_to_continued_fraction_top_tb.sv
// Testbench for the continued fraction expander top level.
// Drives fractions and term-limit writes, predicts every term word, checks them in order.
// Depends on rcf_pkg and rational_to_continued_fraction_top.
module rational_to_continued_fraction_top_tb
    import rcf_pkg::*;
();

    localparam int MAX_TERM_COUNT = 64;
    localparam int STALL_LIMIT    = 6000;
    localparam int MAX_PRINTED    = 40;

    // One expected term word
    typedef struct packed {
        logic [VALUE_WIDTH-1:0] term;
        logic                   last_term;
        logic                   truncated;
        logic                   zero_denominator;
    } term_word_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [VALUE_WIDTH-1:0] numerator = '0;
    logic [DEN_WIDTH-1:0]          denominator = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [VALUE_WIDTH-1:0] term;
    logic                          last_term;
    logic                          truncated;
    logic                          zero_denominator;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [LIMIT_WIDTH-1:0]        cfg_data = '0;

    term_word_t             expected_terms[$];
    term_word_t             want;
    logic [LIMIT_WIDTH-1:0] term_limit_now = LIMIT_RESET;
    int                     sender_idle_pct = 0;
    int                     recv_stall_pct = 0;
    int                     hold_request = 0;
    int                     hold_left = 0;
    int                     error_count = 0;
    int                     quiet_cycles = 0;
    int                     fractions_sent = 0;
    int                     words_checked = 0;
    int                     truncated_seen = 0;
    int                     zero_den_seen = 0;
    int                     limit_writes = 0;

    rational_to_continued_fraction_top dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .numerator        (numerator),
        .denominator      (denominator),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .term             (term),
        .last_term        (last_term),
        .truncated        (truncated),
        .zero_denominator (zero_denominator),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data)
    );

    always #5 clk = ~clk;

    // Predict the term words of one fraction: floor quotients, Euclidean steps
    function automatic void expand_fraction(input logic signed [VALUE_WIDTH-1:0] num,
                                            input logic [DEN_WIDTH-1:0] den);
        longint     p;
        longint     q;
        longint     t;
        longint     r;
        int         count;
        int         cap;
        bit         done;
        bit         cut;
        term_word_t w;
        if (den == '0)
        begin
            w = '{term: '0, last_term: 1'b1, truncated: 1'b0, zero_denominator: 1'b1};
            expected_terms.insert(expected_terms.size(), w);
            return;
        end
        cap = int'(term_limit_now) + 1;
        if (cap > MAX_TERM_COUNT)
            cap = MAX_TERM_COUNT;
        p = longint'(num);
        q = longint'({1'b0, den});
        count = 0;
        do
        begin
            t = p / q;
            r = p % q;
            // truncating division: pull negative remainders back into range
            if (r < 0)
            begin
                t = t - 1;
                r = r + q;
            end
            count++;
            done = (r == 0);
            cut  = !done && (count >= cap);
            w.term             = t[VALUE_WIDTH-1:0];
            w.last_term        = done || cut;
            w.truncated        = cut;
            w.zero_denominator = 1'b0;
            expected_terms.insert(expected_terms.size(), w);
            p = q;
            q = r;
        end
        while (!(done || cut));
    endfunction

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED)
            $display("%0t MISMATCH: %s", $realtime, msg);
    endtask

    // Offer one fraction; valid stays up until taken, never dropped and raised in one step
    task automatic send_fraction(input logic signed [VALUE_WIDTH-1:0] num,
                                 input logic [DEN_WIDTH-1:0] den);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        numerator   <= num;
        denominator <= den;
        do
            @(posedge clk);
        while (!in_ready);
        expand_fraction(num, den);
        fractions_sent++;
    endtask

    // Sender drops valid and pauses until every expected word is back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (expected_terms.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_term_limit(input logic [LIMIT_WIDTH-1:0] value);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        term_limit_now = value;
        limit_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Random fraction, with zero denominators, short and exact expansions now and then
    task automatic random_fraction(output logic signed [VALUE_WIDTH-1:0] num,
                                   output logic [DEN_WIDTH-1:0] den);
        int k;
        case ($urandom_range(9))
            0:
            begin
                den = '0;
                num = $urandom;
            end
            1, 2:
            begin
                den = DEN_WIDTH'($urandom_range(1, 255));
                num = $urandom;
            end
            3:
            begin
                den = DEN_WIDTH'($urandom_range(1, 255));
                num = VALUE_WIDTH'(int'($urandom_range(2000)) - 1000);
            end
            4:
            begin
                den = DEN_WIDTH'($urandom_range(1, 1000));
                k   = int'($urandom_range(2000)) - 1000;
                num = VALUE_WIDTH'(k * int'(den));
            end
            default:
            begin
                den = DEN_WIDTH'($urandom);
                num = $urandom;
            end
        endcase
    endtask

    // Receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check each accepted word against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_terms.size() == 0)
                report_mismatch($sformatf("unexpected word, term %0d", term));
            else
            begin
                want = expected_terms.pop_front();
                words_checked++;
                if (want.truncated)
                    truncated_seen++;
                if (want.zero_denominator)
                    zero_den_seen++;
                if (term !== want.term)
                    report_mismatch($sformatf("term %0d, expected %0d",
                                              term, $signed(want.term)));
                if (last_term !== want.last_term)
                    report_mismatch($sformatf("last_term %b, expected %b",
                                              last_term, want.last_term));
                if (truncated !== want.truncated)
                    report_mismatch($sformatf("truncated %b, expected %b",
                                              truncated, want.truncated));
                if (zero_denominator !== want.zero_denominator)
                    report_mismatch($sformatf("zero_denominator %b, expected %b",
                                              zero_denominator, want.zero_denominator));
            end
        end
    end

    // Watchdog: too long without any word moving on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", quiet_cycles);
                $display("rational_to_continued_fraction_top_tb: errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Field extremes, zero denominators, exact and long expansions
    task automatic test_extremes();
        send_fraction(32'sd0, 31'd1);
        send_fraction(32'h8000_0000, 31'd1);
        send_fraction(32'h7FFF_FFFF, 31'd1);
        send_fraction(32'sd5, 31'd0);
        send_fraction(32'h8000_0000, 31'd0);
        send_fraction(32'h7FFF_FFFF, 31'd0);
        send_fraction(32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_fraction(32'h8000_0000, 31'h7FFF_FFFF);
        send_fraction(-32'sd1, 31'h7FFF_FFFF);
        send_fraction(32'sd1, 31'h7FFF_FFFF);
        send_fraction(32'sd1836311903, 31'd1134903170);
        send_fraction(-32'sd7, 31'd3);
        send_fraction(32'sd7, 31'd3);
        send_fraction(-32'sd12, 31'd4);
        send_fraction(32'sd12, 31'd4);
        send_fraction(-32'sd1, 31'd1);
        wait_for_drain();
    endtask

    // Truncation at small and mid limits, then back to the widest
    task automatic test_term_limits();
        set_term_limit(6'd0);
        send_fraction(32'sd7, 31'd3);
        send_fraction(32'sd12, 31'd4);
        send_fraction(32'sd9, 31'd0);
        set_term_limit(6'd1);
        send_fraction(32'sd7, 31'd3);
        send_fraction(32'sd10, 31'd7);
        set_term_limit(6'd42);
        send_fraction(32'sd1836311903, 31'd1134903170);
        send_fraction(-32'sd1836311903, 31'd1134903170);
        set_term_limit(LIMIT_RESET);
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input logic [LIMIT_WIDTH-1:0] limit, input int count);
        logic signed [VALUE_WIDTH-1:0] num;
        logic [DEN_WIDTH-1:0]          den;
        set_term_limit(limit);
        sender_idle_pct = idle_pct;
        recv_stall_pct  = stall_pct;
        repeat (count)
        begin
            random_fraction(num, den);
            send_fraction(num, den);
        end
        wait_for_drain();
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
    endtask

    // Receiver holds off while fractions keep coming, so the input backs up
    task automatic test_backpressure();
        logic signed [VALUE_WIDTH-1:0] num;
        logic [DEN_WIDTH-1:0]          den;
        hold_request = 400;
        repeat (8)
        begin
            random_fraction(num, den);
            send_fraction(num, den);
        end
        wait_for_drain();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_term_limits();
        test_random_phase(0, 0, 6'd63, 60);
        test_random_phase(53, 0, 6'd5, 60);
        test_random_phase(0, 53, LIMIT_WIDTH'($urandom_range(63)), 60);
        test_random_phase(9, 9, 6'd21, 60);
        test_backpressure();

        wait_for_drain();
        repeat (100) @(posedge clk);
        $display("run covered %0d fractions over %0d term-limit writes: %0d words checked,",
                 fractions_sent, limit_writes, words_checked);
        $display("  %0d truncated expansions, %0d zero denominators, %0d mismatches",
                 truncated_seen, zero_den_seen, error_count);
        if (error_count == 0)
            $display("rational_to_continued_fraction_top_tb: clean");
        else
            $display("rational_to_continued_fraction_top_tb: errors");
        $finish;
    end

endmodule
